### rtl/psnc_pkg.sv
package psnc_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam int COMP_W  = 6;
  localparam int ENTRY_W = 3 * COMP_W;
  localparam int IDX_W   = 8;
  localparam int LIGHT_W = 8;

  // c * (N - L) + N/2 stays below 2**14 for 6-bit c and 8-bit N
  localparam int PROD_W     = 14;
  localparam int DIV_STEPS  = PROD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int DIST_W     = 14;
  localparam int BEST_W     = DIST_W + 1;

  localparam logic [LIGHT_W-1:0] LIGHTS_RESET = 8'd32;
  localparam logic [BEST_W-1:0]  DIST_START   = 15'd32000;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic               is_lookup;
    logic               drop;      // write beyond the palette
    logic               self_map;  // last color maps to itself
    logic               black;     // lookup of a color beyond the palette
    logic [IDX_W-1:0]   index;
    logic [COMP_W-1:0]  red;
    logic [COMP_W-1:0]  green;
    logic [COMP_W-1:0]  blue;
    logic [LIGHT_W-1:0] scale;     // N - clamped level
    logic [LIGHT_W-1:0] n;         // effective light count, never zero
  } cmd_t;

endpackage

### rtl/psnc_ram.sv
module psnc_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/psnc_front.sv
module psnc_front #(
  parameter int PALETTE_ENTRIES = psnc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [psnc_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [psnc_pkg::COMP_W-1:0]    in_red,
  input  logic [psnc_pkg::COMP_W-1:0]    in_green,
  input  logic [psnc_pkg::COMP_W-1:0]    in_blue,
  input  logic [psnc_pkg::LIGHT_W-1:0]   in_light_level,
  input  logic [psnc_pkg::IDX_W-1:0]     in_color_index,
  input  logic [psnc_pkg::LIGHT_W-1:0]   num_lights,
  input  logic                           pop,
  output logic                           head_vld,
  output psnc_pkg::cmd_t                 head
);

  // two-entry queue toward the back end
  psnc_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  psnc_pkg::cmd_t                 cmd;
  logic [psnc_pkg::LIGHT_W-1:0]   n_eff;
  logic [psnc_pkg::LIGHT_W-1:0]   lvl;
  logic                           push;

  always_comb begin
    n_eff = (num_lights == '0) ? psnc_pkg::LIGHT_W'(1) : num_lights;
    lvl   = (in_light_level > n_eff) ? n_eff : in_light_level;

    cmd.is_lookup = (in_kind == psnc_pkg::KIND_LOOKUP);
    cmd.drop      = (32'(in_entry_index) >= 32'(PALETTE_ENTRIES));
    cmd.self_map  = (32'(in_color_index) == 32'(PALETTE_ENTRIES - 1));
    cmd.black     = (32'(in_color_index) >= 32'(PALETTE_ENTRIES));
    cmd.index     = (in_kind == psnc_pkg::KIND_LOOKUP) ? in_color_index : in_entry_index;
    cmd.red       = in_red;
    cmd.green     = in_green;
    cmd.blue      = in_blue;
    cmd.scale     = n_eff - lvl;
    cmd.n         = n_eff;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign head_vld = (cnt_r != 2'd0);
  assign head     = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

### rtl/psnc_back.sv
module psnc_back #(
  parameter int PALETTE_ENTRIES = psnc_pkg::PALETTE_ENTRIES_DEF,
  parameter int AW              = $clog2(PALETTE_ENTRIES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_vld,
  input  psnc_pkg::cmd_t                head,
  output logic                          pop,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output logic [psnc_pkg::ENTRY_W-1:0]  ram_wdata,
  output logic [AW-1:0]                 ram_raddr,
  input  logic [psnc_pkg::ENTRY_W-1:0]  ram_rdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [psnc_pkg::IDX_W-1:0]    out_best_index
);

  localparam logic [AW-1:0] LAST_IDX = AW'(PALETTE_ENTRIES - 2);
  localparam int CW = psnc_pkg::COMP_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SRC  = 5'b00010,
    S_DIV  = 5'b00100,
    S_SCAN = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                              state_r, state_nxt;
  psnc_pkg::cmd_t                      cmd_r, cmd_nxt;
  logic [psnc_pkg::PROD_W-1:0]         num_r [3];
  logic [psnc_pkg::PROD_W-1:0]         num_nxt [3];
  logic [psnc_pkg::LIGHT_W-1:0]        rem_r [3];
  logic [psnc_pkg::LIGHT_W-1:0]        rem_nxt [3];
  logic [psnc_pkg::DIV_CNT_W-1:0]      div_cnt_r, div_cnt_nxt;
  logic [AW-1:0]                       scan_addr_r, scan_addr_nxt;
  logic                                issue_r, issue_nxt;
  logic                                rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]                       rd_idx_r, rd_idx_nxt;
  logic                                dist_vld_r, dist_vld_nxt;
  logic [AW-1:0]                       dist_idx_r, dist_idx_nxt;
  logic [psnc_pkg::DIST_W-1:0]         dist_r, dist_nxt;
  logic [psnc_pkg::BEST_W-1:0]         best_dist_r, best_dist_nxt;
  logic [AW-1:0]                       best_idx_r, best_idx_nxt;
  logic [psnc_pkg::IDX_W-1:0]          out_idx_r, out_idx_nxt;

  logic [CW-1:0]                       src_comp [3];
  logic [CW-1:0]                       ent_comp [3];
  logic [CW-1:0]                       diff [3];
  logic [2*CW-1:0]                     sq [3];
  logic [psnc_pkg::LIGHT_W:0]          trial [3];
  logic                                upd;

  // entry components and per-lane distance terms
  always_comb begin
    ent_comp[0] = ram_rdata[3*CW-1:2*CW];
    ent_comp[1] = ram_rdata[2*CW-1:CW];
    ent_comp[2] = ram_rdata[CW-1:0];
    for (int l = 0; l < 3; l++) begin
      src_comp[l] = cmd_r.black ? '0 : ent_comp[l];
      diff[l] = (ent_comp[l] > num_r[l][CW-1:0]) ? (ent_comp[l] - num_r[l][CW-1:0])
                                                  : (num_r[l][CW-1:0] - ent_comp[l]);
      sq[l]    = (2*CW)'(diff[l]) * (2*CW)'(diff[l]);
      trial[l] = {rem_r[l], num_r[l][psnc_pkg::PROD_W-1]};
    end
    dist_nxt = psnc_pkg::DIST_W'(sq[0]) + psnc_pkg::DIST_W'(sq[1])
             + psnc_pkg::DIST_W'(sq[2]);
    upd = dist_vld_r && ({1'b0, dist_r} < best_dist_r);
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    div_cnt_nxt   = div_cnt_r;
    scan_addr_nxt = scan_addr_r;
    issue_nxt     = issue_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = scan_addr_r;
    dist_vld_nxt  = 1'b0;
    dist_idx_nxt  = rd_idx_r;
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    out_idx_nxt   = out_idx_r;
    for (int l = 0; l < 3; l++) begin
      num_nxt[l] = num_r[l];
      rem_nxt[l] = rem_r[l];
    end
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AW'(head.index);
    ram_wdata = {head.red, head.green, head.blue};
    ram_raddr = AW'(head.index);

    case (state_r)
      S_IDLE: begin
        if (head_vld) begin
          pop     = 1'b1;
          cmd_nxt = head;
          if (!head.is_lookup) begin
            ram_we = !head.drop;
          end else if (head.self_map) begin
            out_idx_nxt = head.index;
            state_nxt   = S_OUT;
          end else begin
            state_nxt = S_SRC;
          end
        end
      end
      S_SRC: begin
        // source entry arrives; scale and add rounding term
        for (int l = 0; l < 3; l++) begin
          num_nxt[l] = psnc_pkg::PROD_W'(src_comp[l]) * psnc_pkg::PROD_W'(cmd_r.scale)
                     + psnc_pkg::PROD_W'(cmd_r.n[psnc_pkg::LIGHT_W-1:1]);
          rem_nxt[l] = '0;
        end
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        // restoring divide by N, one quotient bit per cycle on each lane
        for (int l = 0; l < 3; l++) begin
          if (trial[l] >= {1'b0, cmd_r.n}) begin
            rem_nxt[l] = psnc_pkg::LIGHT_W'(trial[l] - {1'b0, cmd_r.n});
            num_nxt[l] = {num_r[l][psnc_pkg::PROD_W-2:0], 1'b1};
          end else begin
            rem_nxt[l] = trial[l][psnc_pkg::LIGHT_W-1:0];
            num_nxt[l] = {num_r[l][psnc_pkg::PROD_W-2:0], 1'b0};
          end
        end
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == psnc_pkg::DIV_CNT_W'(psnc_pkg::DIV_STEPS - 1)) begin
          scan_addr_nxt = '0;
          issue_nxt     = 1'b1;
          best_dist_nxt = psnc_pkg::DIST_START;
          best_idx_nxt  = '0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        // read -> distance register -> compare
        ram_raddr    = scan_addr_r;
        rd_vld_nxt   = issue_r;
        dist_vld_nxt = rd_vld_r;
        if (issue_r) begin
          scan_addr_nxt = scan_addr_r + 1'b1;
          if (scan_addr_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end
        end
        if (upd) begin
          best_dist_nxt = {1'b0, dist_r};
          best_idx_nxt  = dist_idx_r;
        end
        if (dist_vld_r && dist_idx_r == LAST_IDX) begin
          out_idx_nxt = upd ? psnc_pkg::IDX_W'(dist_idx_r) : psnc_pkg::IDX_W'(best_idx_r);
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid      = (state_r == S_OUT);
  assign out_best_index = out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      issue_r    <= 1'b0;
      rd_vld_r   <= 1'b0;
      dist_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      issue_r    <= issue_nxt;
      rd_vld_r   <= rd_vld_nxt;
      dist_vld_r <= dist_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    div_cnt_r   <= div_cnt_nxt;
    scan_addr_r <= scan_addr_nxt;
    rd_idx_r    <= rd_idx_nxt;
    dist_idx_r  <= dist_idx_nxt;
    dist_r      <= dist_nxt;
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
    out_idx_r   <= out_idx_nxt;
    for (int l = 0; l < 3; l++) begin
      num_r[l] <= num_nxt[l];
      rem_r[l] <= rem_nxt[l];
    end
  end

endmodule

### rtl/palette_shade_nearest_color.sv
// Shaded palette lookup. Load palette entries with write items (kind 0), which
// give no result and are written as they leave the queue. A lookup item (kind 1)
// darkens one palette color by light_level out of num_lights levels and returns
// the index of the nearest entry among 0 to PALETTE_ENTRIES-2; the last color
// returns itself without a scan. Any other lookup leaves the queue and reads the
// source color, scales it, takes 14 divide steps for the rounding scale, then
// goes one entry per cycle through the single palette read port, passing the
// read and distance registers, then gives the result. A two-item queue sits in
// front, so new items are taken while a lookup runs or a result waits. Write
// num_lights only while the block is idle.
module palette_shade_nearest_color #(
  parameter int PALETTE_ENTRIES = psnc_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psnc_pkg::LIGHT_W-1:0]   cfg_num_lights,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [psnc_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [psnc_pkg::COMP_W-1:0]    in_red,
  input  logic [psnc_pkg::COMP_W-1:0]    in_green,
  input  logic [psnc_pkg::COMP_W-1:0]    in_blue,
  input  logic [psnc_pkg::LIGHT_W-1:0]   in_light_level,
  input  logic [psnc_pkg::IDX_W-1:0]     in_color_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [psnc_pkg::IDX_W-1:0]     out_best_index
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic [psnc_pkg::LIGHT_W-1:0]  num_lights_r;
  logic                          head_vld;
  psnc_pkg::cmd_t                head;
  logic                          pop;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [psnc_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [psnc_pkg::ENTRY_W-1:0]  ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_lights_r <= psnc_pkg::LIGHTS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_lights_r <= cfg_num_lights;
    end
  end

  psnc_front #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_light_level (in_light_level),
    .in_color_index (in_color_index),
    .num_lights     (num_lights_r),
    .pop            (pop),
    .head_vld       (head_vld),
    .head           (head)
  );

  psnc_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .AW              (AW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_vld       (head_vld),
    .head           (head),
    .pop            (pop),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_best_index (out_best_index)
  );

  psnc_ram #(
    .WIDTH (psnc_pkg::ENTRY_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_vld)
    else $error("pop from empty queue");

  a_write_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (pop && !head.is_lookup))
    else $error("palette write without a popped write item");

  a_no_write_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !ram_we)
    else $error("palette written while a result is pending");

  a_lookup_holds_back: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.is_lookup) |=> !pop)
    else $error("back end popped during a lookup");

endmodule
